FILE: design/kmpc_pkg.sv
// Shared constants and types for the pattern occurrence counter.
package kmpc_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int COUNT_BITS  = 16;
    localparam int OUT_DATA_W  = ((COUNT_BITS + 7) / 8) * 8;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_TEXT   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // per-item command broadcast to every cell
    typedef struct packed {
        logic append;   // store symbol in first free cell
        logic text;     // advance matcher by symbol
        logic clear;    // drop the whole pattern
    } t_cell_ctrl;

    // row summary back to the control logic
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
    } t_row_stat;

endpackage

FILE: design/kmp_occurrence_counter_top.sv
// Top level: stream handshake, command decode, occurrence counter and output register.
// One result item per input item, shown in the cycle after the input is accepted.
// Throughput: one item per cycle; the cell row takes a text byte without ever holding it,
// so the only stall comes from the output register waiting on the downstream side.
// Reset (i_rst_n low, synchronous): pattern emptied, match bits and count cleared,
// output register empty. Pattern bytes themselves are not reset.
module kmp_occurrence_counter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] symbol
    input  logic [1:0]                        i_s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [kmpc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // [COUNT_BITS-1:0] occurrences
    output logic [2:0]                        o_m_axis_tuser   // [0] hit, [2:1] status
);
    import kmpc_pkg::*;

    logic                  w_accept;
    t_cell_ctrl            w_ctrl;
    t_row_stat             w_stat;
    logic [1:0]            w_status;
    logic                  w_hit;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [1:0]            r_out_status;
    logic [COUNT_BITS-1:0] r_out_count;

    // new item whenever the output slot is free or being drained this cycle
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    // decode the item into cell commands and a status code
    always_comb begin
        w_ctrl   = '0;
        w_status = STAT_OK;
        case (i_s_axis_tuser)
            MODE_APPEND: begin
                if (w_stat.full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ctrl.append = w_accept;
                end
            end
            MODE_TEXT: begin
                if (w_stat.empty) begin
                    w_status = STAT_EMPTY;
                end else begin
                    w_ctrl.text = w_accept;
                end
            end
            MODE_CLEAR: begin
                w_ctrl.clear = w_accept;
            end
            default: begin
                w_status = STAT_OK;   // unused mode: no effect
            end
        endcase
    end

    kmpc_cell_row u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_symbol (i_s_axis_tdata),
        .o_stat   (w_stat)
    );

    assign w_hit = w_stat.hit;   // already gated by the text command

    // count restarts on any pattern change, saturates at all ones
    always_comb begin
        n_count = r_count;
        if (w_ctrl.append || w_ctrl.clear) begin
            n_count = '0;
        end else if (w_hit && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_hit    <= w_hit;
            r_out_status <= w_status;
            r_out_count  <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_count);
    assign o_m_axis_tuser  = {r_out_status, r_out_hit};

    // an accepted item always lands in the output register
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    // clear empties the count and reports zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == MODE_CLEAR) |=> (r_count == '0 && r_out_count == '0))
        else $error("clear left a nonzero count");

    // text against empty pattern flags and never hits
    a_empty_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == MODE_TEXT && w_stat.empty)
        |=> (r_out_status == STAT_EMPTY && !r_out_hit))
        else $error("text with empty pattern misreported");

    // count only drops through a pattern change
    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < $past(r_count)) |-> $past(w_ctrl.append || w_ctrl.clear))
        else $error("count decreased without pattern change");

endmodule

FILE: design/kmpc_cell.sv
// One pattern cell: holds a pattern byte, its in-use flag and its prefix match bit.
module kmpc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmpc_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]        i_symbol,
    input  logic              i_prev_used,
    input  logic              i_prev_match,
    input  logic              i_next_used,
    output logic              o_used,
    output logic              o_match,
    output logic              o_hit
);
    import kmpc_pkg::*;

    logic [7:0] r_byte;
    logic       r_used;
    logic       r_match;
    logic       n_match;
    logic       w_take;

    // first free cell takes the appended byte
    assign w_take  = i_ctrl.append & i_prev_used & ~r_used;
    // prefix [0..this] ends at the current text byte
    assign n_match = r_used & i_prev_match & (i_symbol == r_byte);
    // full occurrence when this is the last used cell
    assign o_hit   = i_ctrl.text & n_match & ~i_next_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_used <= 1'b0;
            end else if (w_take) begin
                r_used <= 1'b1;
            end
            if (i_ctrl.clear || i_ctrl.append) begin
                r_match <= 1'b0;
            end else if (i_ctrl.text) begin
                r_match <= n_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_symbol;
        end
    end

    assign o_used  = r_used;
    assign o_match = r_match;

endmodule

FILE: design/kmpc_cell_row.sv
// Row of pattern cells; match bits shift one cell per text byte.
module kmpc_cell_row (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmpc_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]           i_symbol,
    output kmpc_pkg::t_row_stat  o_stat
);
    import kmpc_pkg::*;

    logic [MAX_PATTERN-1:0] w_used;
    logic [MAX_PATTERN-1:0] w_match;
    logic [MAX_PATTERN-1:0] w_hit;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic w_prev_used;
        logic w_prev_match;
        logic w_next_used;

        if (j == 0) begin : g_head
            assign w_prev_used  = 1'b1;
            assign w_prev_match = 1'b1;
        end else begin : g_body
            assign w_prev_used  = w_used[j-1];
            assign w_prev_match = w_match[j-1];
        end

        if (j == MAX_PATTERN - 1) begin : g_tail
            assign w_next_used = 1'b0;
        end else begin : g_mid
            assign w_next_used = w_used[j+1];
        end

        kmpc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_symbol     (i_symbol),
            .i_prev_used  (w_prev_used),
            .i_prev_match (w_prev_match),
            .i_next_used  (w_next_used),
            .o_used       (w_used[j]),
            .o_match      (w_match[j]),
            .o_hit        (w_hit[j])
        );
    end

    assign o_stat.full  = w_used[MAX_PATTERN-1];
    assign o_stat.empty = ~w_used[0];
    assign o_stat.hit   = |w_hit;

endmodule

FILE: test/kmp_occurrence_counter_top_test.sv
// Self-checking testbench for the pattern occurrence counter: predicts every result item.
module kmp_occurrence_counter_top_test;

    import kmpc_pkg::*;

    // mode 3 has no meaning in the block; it must be ignored
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE_CYCLES = 6;    // output register plus margin
    localparam int          MAX_REPORTS = 40;     // keep a broken run from flooding the log
    localparam int          RUN_HITS    = 40;     // back-to-back hits on a one-byte pattern

    // one result item as the block should present it
    typedef struct packed {
        logic                  hit;
        logic [COUNT_BITS-1:0] occurrences;
        logic [1:0]            status;
    } t_match_outcome;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [7:0]            s_sym   = 8'd0;
    logic [1:0]            s_mode  = MODE_APPEND;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [2:0]            o_m_axis_tuser;

    kmp_occurrence_counter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_sym),           // [7:0] symbol
        .i_s_axis_tuser  (s_mode),          // [1:0] mode
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [COUNT_BITS-1:0] occurrences
        .o_m_axis_tuser  (o_m_axis_tuser)   // [0] hit, [2:1] status
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Matcher shadow: pattern, prefix-suffix table, match position and
    // the saturating tally, all updated as each item is accepted.
    // ---------------------------------------------------------------
    logic [7:0]     pat_bytes [MAX_PATTERN];
    int             fail_len  [MAX_PATTERN];
    int             pat_len   = 0;
    int             build_k   = 0;
    int             match_k   = 0;
    int unsigned    tally     = 0;
    t_match_outcome awaited_outcomes [$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    int items_sent      = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    task automatic advance_matcher(input logic [1:0] mode, input logic [7:0] sym);
        t_match_outcome res;
        int             k;
        res = '0;
        case (mode)
            MODE_APPEND: begin
                if (pat_len >= MAX_PATTERN) begin
                    res.status = STAT_FULL;   // byte dropped, nothing changes
                end else begin
                    k = 0;
                    pat_bytes[pat_len] = sym;
                    // extend the table from the prefix length at the last byte
                    if (pat_len != 0) begin
                        k = build_k;
                        while (k > 0 && pat_bytes[k] != sym)
                            k = fail_len[k-1];
                        if (pat_bytes[k] == sym)
                            k++;
                    end
                    fail_len[pat_len] = k;
                    build_k = k;
                    pat_len++;
                    match_k = 0;
                    tally   = 0;
                end
            end
            MODE_TEXT: begin
                if (pat_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    k = match_k;
                    while (k > 0 && pat_bytes[k] != sym)
                        k = fail_len[k-1];
                    if (pat_bytes[k] == sym)
                        k++;
                    if (k == pat_len) begin
                        // full occurrence; fall back so overlaps still count
                        res.hit = 1'b1;
                        if (tally < COUNT_MAX)
                            tally++;
                        k = fail_len[pat_len-1];
                    end
                    match_k = k;
                end
            end
            MODE_CLEAR: begin
                pat_len = 0;
                build_k = 0;
                match_k = 0;
                tally   = 0;
            end
            default: ;
        endcase
        res.occurrences = tally[COUNT_BITS-1:0];
        awaited_outcomes.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // Sender: optional random gap, then hold the item until tready.
    // tvalid stays high across back-to-back items.
    // ---------------------------------------------------------------
    task automatic send_item(input logic [1:0] mode, input logic [7:0] sym);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_sym   <= sym;
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_matcher(mode, sym);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    // sender pause until every result is back, then let the pipe settle
    task automatic wait_results_drained;
        s_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when requested.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker: every accepted item against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_match_outcome want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (awaited_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result expected none actual tdata=%h tuser=%b",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_m_axis_tuser[0] !== want.hit) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: hit mismatch expected %0d actual %0d",
                                 $time, want.hit, o_m_axis_tuser[0]);
                end
                if (o_m_axis_tdata[COUNT_BITS-1:0] !== want.occurrences) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: occurrences mismatch expected %0d actual %0d",
                                 $time, want.occurrences, o_m_axis_tdata[COUNT_BITS-1:0]);
                end
                if (o_m_axis_tuser[2:1] !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, o_m_axis_tuser[2:1]);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_idling(input int sender_pct, input int recv_pct);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // field extremes, every mode, empty-pattern text, overlap, clear
    task automatic test_directed;
        send_item(MODE_TEXT,   8'h00);   // text before any pattern
        send_item(MODE_TEXT,   8'hFF);
        send_item(MODE_UNUSED, 8'hA5);   // ignored mode
        send_item(MODE_APPEND, 8'h00);
        send_item(MODE_APPEND, 8'hFF);
        send_item(MODE_APPEND, 8'h00);   // pattern 00 FF 00, border of one
        send_item(MODE_TEXT,   8'h00);
        send_item(MODE_TEXT,   8'hFF);
        send_item(MODE_TEXT,   8'h00);   // hit
        send_item(MODE_TEXT,   8'hFF);
        send_item(MODE_TEXT,   8'h00);   // overlapping hit
        send_item(MODE_TEXT,   8'hFF);
        send_item(MODE_TEXT,   8'hFF);   // mismatch falls back to start
        send_item(MODE_UNUSED, 8'h5A);   // count shown unchanged
        send_item(MODE_APPEND, 8'h00);   // growing the pattern zeroes the count
        send_item(MODE_TEXT,   8'h00);
        send_item(MODE_TEXT,   8'hFF);
        send_item(MODE_TEXT,   8'h00);
        send_item(MODE_TEXT,   8'h00);   // hit on 00 FF 00 00
        send_item(MODE_CLEAR,  8'hFF);
        send_item(MODE_TEXT,   8'h12);   // empty again
        send_item(MODE_CLEAR,  8'h00);
    endtask

    // fill all pattern slots, overflow, then match a periodic text
    task automatic test_pattern_full;
        logic [7:0] alpha [3];
        alpha[0] = 8'($urandom_range(255));
        alpha[1] = ~alpha[0];
        alpha[2] = 8'($urandom_range(255));
        send_item(MODE_CLEAR, 8'h00);
        for (int i = 0; i < MAX_PATTERN; i++)
            send_item(MODE_APPEND, alpha[i % 3]);
        send_item(MODE_APPEND, 8'hFF);   // dropped
        send_item(MODE_APPEND, 8'h00);   // dropped
        for (int i = 0; i < 3 * MAX_PATTERN; i++)
            send_item(MODE_TEXT, alpha[i % 3]);
        send_item(MODE_CLEAR, 8'h00);
    endtask

    // one-byte pattern hit on every text byte, count climbs by one each time
    task automatic test_count_run;
        send_item(MODE_CLEAR,  8'h00);
        send_item(MODE_APPEND, 8'h5A);
        for (int i = 0; i < RUN_HITS; i++)
            send_item(MODE_TEXT, 8'h5A);
        send_item(MODE_TEXT,   8'hA5);   // no hit, count holds
        send_item(MODE_APPEND, 8'h3C);   // count restarts
        send_item(MODE_TEXT,   8'h5A);
        send_item(MODE_TEXT,   8'h3C);
        wait_results_drained();
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure;
        send_item(MODE_CLEAR,  8'h00);
        send_item(MODE_APPEND, 8'h41);
        send_item(MODE_APPEND, 8'h42);
        hold_left = 300;
        for (int i = 0; i < 60; i++)
            send_item(MODE_TEXT, ($urandom_range(1) != 0) ? 8'h41 : 8'h42);
    endtask

    // sender pauses mid-stream until every result is back
    task automatic test_drain_pause;
        for (int i = 0; i < 20; i++)
            send_item(MODE_TEXT, ($urandom_range(1) != 0) ? 8'h41 : 8'h42);
        wait_results_drained();
        for (int i = 0; i < 20; i++)
            send_item(MODE_TEXT, ($urandom_range(1) != 0) ? 8'h41 : 8'h42);
    endtask

    // mostly load-then-search sequences over a tiny alphabet, plus noise
    task automatic test_random_traffic(input int n_items);
        int         stop_at;
        int         plen;
        int         tlen;
        int         r;
        logic [7:0] alpha [3];
        logic [7:0] pat [MAX_PATTERN];
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                alpha[0] = 8'($urandom_range(255));
                alpha[1] = alpha[0] ^ (8'd1 << $urandom_range(7));
                alpha[2] = 8'($urandom_range(255));
                // skipping the clear now and then grows an old pattern
                if ($urandom_range(9) != 0)
                    send_item(MODE_CLEAR, 8'($urandom_range(255)));
                if ($urandom_range(11) == 0)
                    plen = $urandom_range(12, MAX_PATTERN);
                else
                    plen = $urandom_range(1, 5);
                for (int i = 0; i < plen; i++) begin
                    pat[i] = ($urandom_range(15) == 0) ? alpha[2] : alpha[$urandom_range(1)];
                    send_item(MODE_APPEND, pat[i]);
                end
                if (plen == MAX_PATTERN && $urandom_range(1) != 0)
                    send_item(MODE_APPEND, 8'($urandom_range(255)));
                tlen = $urandom_range(6, 40);
                for (int i = 0; i < tlen; i++) begin
                    r = $urandom_range(19);
                    if (r == 0) begin
                        for (int j = 0; j < plen; j++)
                            send_item(MODE_TEXT, pat[j]);
                    end else if (r == 1) begin
                        send_item(MODE_TEXT, 8'($urandom_range(255)));
                    end else if (r == 2) begin
                        send_item(MODE_UNUSED, 8'($urandom_range(255)));
                    end else begin
                        send_item(MODE_TEXT, alpha[$urandom_range(1)]);
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence of the run
    // ---------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed();
        test_pattern_full();
        test_count_run();
        test_backpressure();
        test_drain_pause();

        // idling phases: none, sender only, receiver only, both
        set_idling(0, 0);
        test_random_traffic(360);
        set_idling(77, 0);
        test_random_traffic(360);
        set_idling(0, 77);
        test_random_traffic(360);
        set_idling(34, 34);
        test_random_traffic(360);

        wait_results_drained();
        mismatch_count += awaited_outcomes.size();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
design/kmpc_pkg.sv
design/kmpc_cell.sv
design/kmpc_cell_row.sv
design/kmp_occurrence_counter_top.sv
test/kmp_occurrence_counter_top_test.sv
